[design/kvi_pkg.sv]
package kvi_pkg;

	localparam int MAX_KEYS   = 32;
	localparam int TIME_BITS  = 24;
	localparam int NCH        = 3;
	localparam int IDX_W      = $clog2(MAX_KEYS);
	localparam int CNT_W      = $clog2(MAX_KEYS + 1);
	localparam int DIV_NUM_W  = 64;
	localparam int DIV_DEN_W  = 32;
	localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
	localparam int SQRT_ARG_W = 64;
	localparam int SQRT_W     = SQRT_ARG_W / 2;
	localparam int SQRT_CNT_W = $clog2(SQRT_W);
	localparam int PROD_W     = 33 + TIME_BITS;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = TIME_BITS;

	localparam logic [CFG_ADDR_W-1:0] REG_HELPER_KIND = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOOP_LENGTH = 1'b1;

	localparam logic [1:0] KIND_VECTOR = 2'd1;
	localparam logic [1:0] KIND_CAMERA = 2'd2;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [1:0]            channel;
		logic [TIME_BITS-1:0]  key_time;
		logic signed [31:0]    vec_x;
		logic signed [31:0]    vec_y;
		logic signed [31:0]    vec_z;
		logic [15:0]           time_step;
	} req_t;

	typedef struct packed {
		logic [1:0]         out_channel;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] t;
		logic signed [31:0]   x;
		logic signed [31:0]   y;
		logic signed [31:0]   z;
	} key_t;

	typedef key_t [NCH-1:0] row_t;

	typedef struct packed {
		logic [NCH-1:0] ins;
		logic           rot;
		key_t           key;
	} cell_ctl_t;

endpackage

[design/kvi_cell.sv]
module kvi_cell import kvi_pkg::*; (
	input  logic           clk,
	input  cell_ctl_t      ctl,
	input  logic [NCH-1:0] valid,
	input  row_t           prv,
	input  logic [NCH-1:0] prv_le,
	input  row_t           nxt,
	output row_t           row,
	output logic [NCH-1:0] le
);

	row_t row_q;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			le[c] = valid[c] && (row_q[c].t <= ctl.key.t);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (ctl.rot) begin
				row_q[c] <= nxt[c];
			end else if (ctl.ins[c] && !le[c]) begin
				row_q[c] <= prv_le[c] ? ctl.key : prv[c];
			end
		end
	end

	assign row = row_q;

endmodule

[design/kvi_div.sv]
module kvi_div import kvi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 busy,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo,
	output logic [DIV_DEN_W-1:0] rem
);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[design/kvi_isqrt.sv]
module kvi_isqrt import kvi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQRT_ARG_W-1:0] arg,
	output logic                  busy,
	output logic                  done,
	output logic [SQRT_W-1:0]     root
);

	logic [SQRT_ARG_W-1:0] n_q;
	logic [SQRT_W+1:0]     rem_q;
	logic [SQRT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SQRT_W+3:0]     r;
	logic [SQRT_W+3:0]     trial;
	logic [SQRT_W+3:0]     diff;
	logic                  fits;

	assign r     = {rem_q, n_q[SQRT_ARG_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = r - trial;
	assign fits  = r >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CNT_W'(SQRT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= arg;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[SQRT_ARG_W-3:0], 2'b00};
			rem_q  <= fits ? diff[SQRT_W+1:0] : r[SQRT_W+1:0];
			root_q <= {root_q[SQRT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

[design/keyframe_vector_interpolator_core.sv]
// Position add inserts the key at once; direction/up add first normalises it (squares,
//   32-step root, three 64-step divides). Tick: a full rotation scan, plus the loop modulo
//   divide, plus three 64-step divides per result through one shared divider.
// One request at a time; the shared divider and output back-pressure set the tick rate.
// Reset clears key counts, current time, helper_kind and loop_length; key storage is not cleared.
module keyframe_vector_interpolator_core import kvi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_NSQ   = 10'b00_0000_0010,
		S_NSQRT = 10'b00_0000_0100,
		S_NDIV  = 10'b00_0000_1000,
		S_INS   = 10'b00_0001_0000,
		S_TDIV  = 10'b00_0010_0000,
		S_SCAN  = 10'b00_0100_0000,
		S_BMUL  = 10'b00_1000_0000,
		S_BDIV  = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	function automatic logic signed [31:0] comp_of(key_t k, logic [1:0] i);
		logic signed [31:0] v;
		case (i)
			2'd0:    v = k.x;
			2'd1:    v = k.y;
			default: v = k.z;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] mag32(logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	state_t                   state_q;
	req_t                     req_q;
	logic [1:0]               kind_q;
	logic [TIME_BITS-1:0]     loop_q;
	logic [CNT_W-1:0]         cnt_q [NCH];
	logic [TIME_BITS-1:0]     cur_q;
	key_t                     key_q;
	logic [1:0]               ci_q;
	logic [63:0]              acc_q;
	logic [63:0]              sq_s1;
	logic [31:0]              len_q;
	logic [IDX_W-1:0]         rot_q;
	row_t                     pa_q;
	row_t                     pb_q;
	logic [NCH-1:0]           found_q;
	logic [NCH-1:0]           pend_q;
	logic [1:0]               ch_q;
	logic [PROD_W-1:0]        prod_s1;
	logic                     neg_q;
	logic signed [31:0]       p0_q;
	logic [TIME_BITS-1:0]     den_q;
	logic signed [31:0]       res_x_q;
	logic signed [31:0]       res_y_q;
	logic signed [31:0]       res_z_q;
	logic                     div_go_q;
	logic                     sqrt_go_q;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;

	cell_ctl_t                cell_ctl;
	row_t                     rows [MAX_KEYS];
	logic [NCH-1:0]           les [MAX_KEYS];

	logic [DIV_NUM_W-1:0]     div_num;
	logic [DIV_DEN_W-1:0]     div_den;
	logic                     div_busy;
	logic                     div_done;
	logic [DIV_NUM_W-1:0]     div_quo;
	logic [DIV_DEN_W-1:0]     div_rem;
	logic                     sqrt_busy;
	logic                     sqrt_done;
	logic [SQRT_W-1:0]        sqrt_root;

	logic [TIME_BITS:0]       sum_in;
	logic [TIME_BITS:0]       sum_q;
	logic [NCH-1:0]           en;
	logic [NCH-1:0]           hit;
	logic [1:0]               sel_ch;
	key_t                     ka;
	key_t                     kb;
	logic signed [31:0]       p0;
	logic signed [31:0]       p1;
	logic signed [32:0]       d;
	logic [32:0]              md;
	logic [TIME_BITS-1:0]     numt;
	logic [32:0]              blend;
	logic signed [31:0]       ncomp;
	logic [31:0]              nq;
	logic [NCH-1:0]           pend_rest;
	logic                     rsp_load;

	assign req_ready = (state_q == S_IDLE);

	assign sum_in = {1'b0, cur_q} + (TIME_BITS + 1)'(req.time_step);
	assign sum_q  = {1'b0, cur_q} + (TIME_BITS + 1)'(req_q.time_step);

	always_comb begin
		case (kind_q)
			KIND_VECTOR: en = 3'b011;
			KIND_CAMERA: en = 3'b111;
			default:     en = 3'b001;
		endcase
	end

	// chain of key cells; rotation moves cell i+1 into cell i
	assign cell_ctl.ins = (state_q == S_INS) ? (NCH'(1) << req_q.channel) : '0;
	assign cell_ctl.rot = (state_q == S_SCAN);
	assign cell_ctl.key = key_q;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		logic [NCH-1:0] valid;
		for (genvar c = 0; c < NCH; c++) begin : g_vld
			assign valid[c] = CNT_W'(i) < cnt_q[c];
		end
		kvi_cell u_cell (
			.clk    (clk),
			.ctl    (cell_ctl),
			.valid  (valid),
			.prv    ((i == 0) ? rows[MAX_KEYS-1] : rows[(i + MAX_KEYS - 1) % MAX_KEYS]),
			.prv_le ((i == 0) ? {NCH{1'b1}} : les[(i + MAX_KEYS - 1) % MAX_KEYS]),
			.nxt    (rows[(i + 1) % MAX_KEYS]),
			.row    (rows[i]),
			.le     (les[i])
		);
	end

	// rotation step k: cell 0 holds entry k, last cell holds entry k-1
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			hit[c] = (rot_q != '0) && (CNT_W'(rot_q) < cnt_q[c])
				&& (rows[MAX_KEYS-1][c].t <= cur_q) && (rows[0][c].t > cur_q);
		end
	end

	always_comb begin
		if (pend_q[0]) begin
			sel_ch = 2'd0;
		end else if (pend_q[1]) begin
			sel_ch = 2'd1;
		end else begin
			sel_ch = 2'd2;
		end
	end

	assign ka   = pa_q[sel_ch];
	assign kb   = pb_q[sel_ch];
	assign p0   = comp_of(ka, ci_q);
	assign p1   = comp_of(kb, ci_q);
	assign d    = {p1[31], p1} - {p0[31], p0};
	assign md   = d[32] ? 33'(-d) : 33'(d);
	assign numt = cur_q - ka.t;

	assign blend = neg_q ? ({p0_q[31], p0_q} - div_quo[32:0])
		: ({p0_q[31], p0_q} + div_quo[32:0]);

	assign ncomp = comp_of(key_q, ci_q);
	assign nq    = div_quo[31:0];

	assign pend_rest = pend_q & ~(NCH'(1) << ch_q);
	assign rsp_load  = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		div_num = '0;
		div_den = '0;
		if (state_q == S_TDIV) begin
			div_num = DIV_NUM_W'(sum_q - 1'b1);
			div_den = DIV_DEN_W'(loop_q);
		end else if (state_q == S_NDIV) begin
			div_num = {16'b0, mag32(ncomp), 16'b0} + DIV_NUM_W'(len_q[31:1]);
			div_den = len_q;
		end else if (state_q == S_BDIV) begin
			div_num = DIV_NUM_W'(prod_s1) + DIV_NUM_W'(den_q[TIME_BITS-1:1]);
			div_den = DIV_DEN_W'(den_q);
		end
	end

	kvi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	kvi_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_go_q),
		.arg    (acc_q),
		.busy   (sqrt_busy),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= '0;
			loop_q      <= '0;
			for (int c = 0; c < NCH; c++) begin
				cnt_q[c] <= '0;
			end
			cur_q       <= '0;
			div_go_q    <= 1'b0;
			sqrt_go_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			ci_q        <= '0;
			rot_q       <= '0;
			found_q     <= '0;
			pend_q      <= '0;
		end else begin
			div_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_HELPER_KIND: kind_q <= cfg_wdata[1:0];
					REG_LOOP_LENGTH: loop_q <= cfg_wdata;
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						case (req.cmd)
							CMD_ADD: begin
								if ((req.channel < 2'(NCH))
									&& (cnt_q[req.channel] != CNT_W'(MAX_KEYS))) begin
									ci_q <= '0;
									state_q <= (req.channel == 2'd0) ? S_INS : S_NSQ;
								end
							end
							CMD_SET: cur_q <= req.key_time;
							CMD_TICK: begin
								rot_q   <= '0;
								found_q <= '0;
								if ((loop_q != '0) && (sum_in > {1'b0, loop_q})) begin
									div_go_q <= 1'b1;
									state_q  <= S_TDIV;
								end else begin
									cur_q   <= sum_in[TIME_BITS-1:0];
									state_q <= S_SCAN;
								end
							end
							default: begin
								for (int c = 0; c < NCH; c++) begin
									cnt_q[c] <= '0;
								end
							end
						endcase
					end
				end
				S_NSQ: begin
					ci_q <= ci_q + 1'b1;
					if (ci_q == 2'd3) begin
						sqrt_go_q <= 1'b1;
						state_q   <= S_NSQRT;
					end
				end
				S_NSQRT: begin
					if (sqrt_done) begin
						ci_q <= '0;
						if (sqrt_root == '0) begin
							state_q <= S_INS;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= S_NDIV;
						end
					end
				end
				S_NDIV: begin
					if (div_done) begin
						if (ci_q == 2'd2) begin
							state_q <= S_INS;
						end else begin
							ci_q     <= ci_q + 1'b1;
							div_go_q <= 1'b1;
						end
					end
				end
				S_INS: begin
					cnt_q[req_q.channel] <= cnt_q[req_q.channel] + 1'b1;
					state_q <= S_IDLE;
				end
				S_TDIV: begin
					if (div_done) begin
						cur_q   <= div_rem[TIME_BITS-1:0] + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rot_q   <= rot_q + 1'b1;
					found_q <= found_q | hit;
					if (rot_q == IDX_W'(MAX_KEYS - 1)) begin
						pend_q <= (found_q | hit) & en;
						ci_q   <= '0;
						state_q <= (((found_q | hit) & en) != '0) ? S_BMUL : S_IDLE;
					end
				end
				S_BMUL: begin
					div_go_q <= 1'b1;
					state_q  <= S_BDIV;
				end
				S_BDIV: begin
					if (div_done) begin
						if (ci_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							ci_q    <= ci_q + 1'b1;
							state_q <= S_BMUL;
						end
					end
				end
				S_OUT: begin
					if (rsp_load) begin
						pend_q  <= pend_rest;
						ci_q    <= '0;
						state_q <= (pend_rest != '0) ? S_BMUL : S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
			key_q <= '{t: req.key_time, x: req.vec_x, y: req.vec_y, z: req.vec_z};
			acc_q <= '0;
		end
		if (state_q == S_NSQ) begin
			sq_s1 <= mag32(ncomp) * mag32(ncomp);
			if (ci_q != 2'd0) begin
				acc_q <= acc_q + sq_s1;
			end
		end
		if ((state_q == S_NSQRT) && sqrt_done) begin
			len_q <= sqrt_root;
			if (sqrt_root == '0) begin
				key_q.x <= '0;
				key_q.y <= '0;
				key_q.z <= '0;
			end
		end
		if ((state_q == S_NDIV) && div_done) begin
			case (ci_q)
				2'd0:    key_q.x <= ncomp[31] ? -$signed(nq) : $signed(nq);
				2'd1:    key_q.y <= ncomp[31] ? -$signed(nq) : $signed(nq);
				default: key_q.z <= ncomp[31] ? -$signed(nq) : $signed(nq);
			endcase
		end
		if (state_q == S_SCAN) begin
			for (int c = 0; c < NCH; c++) begin
				if (hit[c]) begin
					pa_q[c] <= rows[MAX_KEYS-1][c];
					pb_q[c] <= rows[0][c];
				end
			end
		end
		if (state_q == S_BMUL) begin
			prod_s1 <= md * numt;
			neg_q   <= d[32];
			p0_q    <= p0;
			den_q   <= kb.t - ka.t;
			ch_q    <= sel_ch;
		end
		if ((state_q == S_BDIV) && div_done) begin
			case (ci_q)
				2'd0:    res_x_q <= blend[31:0];
				2'd1:    res_y_q <= blend[31:0];
				default: res_z_q <= blend[31:0];
			endcase
		end
		if (rsp_load) begin
			rsp_q.out_channel <= ch_q;
			rsp_q.out_x       <= res_x_q;
			rsp_q.out_y       <= res_y_q;
			rsp_q.out_z       <= res_z_q;
			rsp_q.last        <= (pend_rest == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!div_busy && !sqrt_busy))
		else $error("divider or root unit busy while idle");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_ctl.ins != '0) |-> (cnt_q[req_q.channel] < CNT_W'(MAX_KEYS)))
		else $error("insert into full table");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && (rot_q == IDX_W'(MAX_KEYS - 1))) |=> (state_q != S_SCAN))
		else $error("scan ran past one full rotation");

	a_blend_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BMUL) |-> (pend_q != '0))
		else $error("blend started with no pending channel");

endmodule

[dv/tb_keyframe_vector_interpolator_core.sv]
`timescale 1ns / 100ps

module tb_keyframe_vector_interpolator_core;
	import kvi_pkg::*;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_ODD   = 2'd3;
	localparam logic [1:0] CH_POS     = 2'd0;
	localparam logic [1:0] CH_DIR     = 2'd1;
	localparam logic [1:0] CH_UP      = 2'd2;
	localparam logic [1:0] CH_NONE    = 2'd3;
	localparam int         DRAIN_CYC  = 400;
	localparam longint     CYCLE_CAP  = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	keyframe_vector_interpolator_core uut (.*);

	always #1 clk = ~clk;

	// interpolator state mirror
	logic [TIME_BITS-1:0] key_t_m[NCH][MAX_KEYS];
	longint key_x_m[NCH][MAX_KEYS];
	longint key_y_m[NCH][MAX_KEYS];
	longint key_z_m[NCH][MAX_KEYS];
	int key_cnt_m[NCH];
	longint unsigned now_m;
	logic [1:0] kind_m;
	longint unsigned loop_m;

	rsp_t expected_rsp[$];
	int errors = 0;
	int items = 0;
	int send_idle = 0;
	int rcv_idle = 0;
	longint cycles = 0;

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unit_comp(longint c, longint unsigned len);
		longint unsigned q;
		q = ((mag(c) << 16) + (len >> 1)) / len;
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint lerp(longint p0, longint p1, longint unsigned num,
			longint unsigned den);
		longint d;
		longint unsigned q;
		d = p1 - p0;
		q = (mag(d) * num + (den >> 1)) / den;
		return (d < 0) ? p0 - longint'(q) : p0 + longint'(q);
	endfunction

	function automatic void insert_key(int ch, logic [TIME_BITS-1:0] t, longint x, longint y,
			longint z);
		int n;
		int p;
		longint unsigned len;
		n = key_cnt_m[ch];
		p = 0;
		if (n >= MAX_KEYS) return;
		if (ch != 0) begin
			len = isqrt(mag(x) * mag(x) + mag(y) * mag(y) + mag(z) * mag(z));
			if (len == 0) begin
				x = 0; y = 0; z = 0;
			end else begin
				x = unit_comp(x, len);
				y = unit_comp(y, len);
				z = unit_comp(z, len);
			end
		end
		while (p < n && key_t_m[ch][p] <= t) p++;
		for (int i = n; i > p; i--) begin
			key_t_m[ch][i] = key_t_m[ch][i-1];
			key_x_m[ch][i] = key_x_m[ch][i-1];
			key_y_m[ch][i] = key_y_m[ch][i-1];
			key_z_m[ch][i] = key_z_m[ch][i-1];
		end
		key_t_m[ch][p] = t;
		key_x_m[ch][p] = x;
		key_y_m[ch][p] = y;
		key_z_m[ch][p] = z;
		key_cnt_m[ch] = n + 1;
	endfunction

	// applies one request to the mirror, returns the vectors it should produce
	function automatic void interpolate(req_t r, ref rsp_t res[$]);
		longint unsigned t;
		longint unsigned num;
		longint unsigned den;
		int nch;
		int i;
		rsp_t o;
		res.delete();
		case (r.cmd)
			CMD_ADD: begin
				if (r.channel != CH_NONE)
					insert_key(int'(r.channel), r.key_time, longint'(r.vec_x),
						longint'(r.vec_y), longint'(r.vec_z));
			end
			CMD_SET: now_m = 64'(r.key_time);
			CMD_CLEAR: key_cnt_m = '{0, 0, 0};
			default: begin
				t = now_m + 64'(r.time_step);
				if (loop_m > 0 && t > loop_m) t = ((t - 1) % loop_m) + 1;
				t &= (64'd1 << TIME_BITS) - 1;
				now_m = t;
				nch = (kind_m == KIND_VECTOR) ? 2 : (kind_m == KIND_CAMERA) ? 3 : 1;
				for (int c = 0; c < nch; c++) begin
					i = 0;
					while (i < key_cnt_m[c] && key_t_m[c][i] <= t) i++;
					if (i == 0 || i >= key_cnt_m[c]) continue;
					num = t - 64'(key_t_m[c][i-1]);
					den = 64'(key_t_m[c][i]) - 64'(key_t_m[c][i-1]);
					if (den == 0) continue;
					o.out_channel = c[1:0];
					o.out_x = 32'(lerp(key_x_m[c][i-1], key_x_m[c][i], num, den));
					o.out_y = 32'(lerp(key_y_m[c][i-1], key_y_m[c][i], num, den));
					o.out_z = 32'(lerp(key_z_m[c][i-1], key_z_m[c][i], num, den));
					o.last = 1'b0;
					res.push_back(o);
				end
				if (res.size() > 0) res[res.size()-1].last = 1'b1;
			end
		endcase
	endfunction

	function automatic void set_idling();
		if (items < 140) begin
			send_idle = 18; rcv_idle = 76;
		end else if (items < 280) begin
			send_idle = 76; rcv_idle = 18;
		end else begin
			send_idle = 0; rcv_idle = 0;
		end
	endfunction

	// literal: expectation typed in the table (no vectors), else from the mirror
	task automatic send(req_t r, bit literal = 0);
		rsp_t res[$];
		set_idling();
		if ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		items++;
		interpolate(r, res);
		if (!literal) foreach (res[k]) expected_rsp.push_back(res[k]);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_rsp.size() > 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (a == REG_HELPER_KIND) kind_m = d[1:0];
		else loop_m = 64'(d);
	endtask

	function automatic req_t mk(cmd_t c, logic [1:0] ch, int unsigned kt, int unsigned x,
			int unsigned y, int unsigned z, int unsigned st);
		req_t r;
		r.cmd = c;
		r.channel = ch;
		r.key_time = TIME_BITS'(kt);
		r.vec_x = x;
		r.vec_y = y;
		r.vec_z = z;
		r.time_step = 16'(st);
		return r;
	endfunction

	function automatic req_t rand_req(int unsigned tspan);
		req_t r;
		int unsigned pick;
		r = mk(CMD_TICK, 2'($urandom_range(0, 3)), 0, $urandom, $urandom, $urandom, 0);
		pick = $urandom_range(0, 99);
		if (pick < 30) r.cmd = CMD_ADD;
		else if (pick < 38) r.cmd = CMD_SET;
		else if (pick < 42) r.cmd = CMD_CLEAR;
		if (r.cmd == CMD_ADD && $urandom_range(0, 9) == 0) r.channel = CH_NONE;
		else if ($urandom_range(0, 9) != 0) r.channel = 2'($urandom_range(0, 2));
		r.key_time = ($urandom_range(0, 4) == 0) ? TIME_BITS'($urandom)
			: TIME_BITS'($urandom_range(0, tspan));
		r.time_step = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		if ($urandom_range(0, 3) == 0) begin
			r.vec_x = $signed($urandom_range(0, 200000)) - 100000;
			r.vec_y = $signed($urandom_range(0, 200000)) - 100000;
			r.vec_z = $urandom_range(0, 1) ? 32'sd0 : r.vec_x;
		end
		return r;
	endfunction

	typedef struct {
		req_t r;
		bit   literal;
	} stim_row_t;

	stim_row_t directed[$];
	logic [1:0] kinds[4] = '{KIND_CAMERA, KIND_VECTOR, KIND_POINT, KIND_ODD};
	int unsigned loops[4] = '{0, 300, 1, 24'hFFFFFF};
	int unsigned spans[4] = '{400, 400, 3, 24'hFFFFFF};

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rcv_idle);
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected vector: ch %0d x %h y %h z %h last %b",
					rsp.out_channel, rsp.out_x, rsp.out_y, rsp.out_z, rsp.last);
				errors++;
			end else begin
				automatic rsp_t e = expected_rsp.pop_front();
				if (rsp.out_channel !== e.out_channel) begin
					$error("out_channel: expected %0d, got %0d", e.out_channel, rsp.out_channel);
					errors++;
				end
				if (rsp.out_x !== e.out_x) begin
					$error("out_x: expected %h, got %h", e.out_x, rsp.out_x);
					errors++;
				end
				if (rsp.out_y !== e.out_y) begin
					$error("out_y: expected %h, got %h", e.out_y, rsp.out_y);
					errors++;
				end
				if (rsp.out_z !== e.out_z) begin
					$error("out_z: expected %h, got %h", e.out_z, rsp.out_z);
					errors++;
				end
				if (rsp.last !== e.last) begin
					$error("last: expected %b, got %b", e.last, rsp.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb_keyframe_vector_interpolator_core: errors");
			$finish;
		end
	end

	initial begin
		key_cnt_m = '{0, 0, 0};
		now_m = 0;
		kind_m = KIND_POINT;
		loop_m = 0;
		directed = '{
			'{mk(CMD_CLEAR, CH_POS, 0, 0, 0, 0, 0), 1},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 16'hFFFF), 1},
			'{mk(CMD_SET, CH_POS, 0, 0, 0, 0, 0), 1},
			'{mk(CMD_ADD, CH_POS, 10, 0, 0, 0, 0), 0},
			'{mk(CMD_ADD, CH_POS, 20, 32'h7FFFFFFF, 32'h80000000, 0, 0), 0},
			'{mk(CMD_ADD, CH_DIR, 10, 0, 0, 0, 0), 0},
			'{mk(CMD_ADD, CH_DIR, 20, 32'hFFFFFFFF, 32'h00010000, 32'h80000000, 0), 0},
			'{mk(CMD_ADD, CH_UP, 20, 32'h80000000, 32'h80000000, 32'h80000000, 0), 0},
			'{mk(CMD_ADD, CH_UP, 10, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0), 0},
			'{mk(CMD_ADD, CH_NONE, 15, 32'h12345678, 0, 0, 0), 0},
			'{mk(CMD_SET, CH_POS, 5, 0, 0, 0, 0), 1},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 0), 1},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 5), 0},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 5), 0},
			'{mk(CMD_ADD, CH_POS, 20, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 0), 0},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 4), 0},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 1), 1},
			'{mk(CMD_SET, CH_POS, 24'hFFFFFF, 0, 0, 0, 0), 1},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 16'hFFFF), 0},
			'{mk(CMD_SET, CH_POS, 3, 0, 0, 0, 0), 1},
			'{mk(CMD_TICK, CH_POS, 0, 0, 0, 0, 14), 0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_HELPER_KIND, CFG_DATA_W'(KIND_CAMERA));
		write_reg(REG_LOOP_LENGTH, '0);
		foreach (directed[k]) send(directed[k].r, directed[k].literal);
		drain();
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_HELPER_KIND, CFG_DATA_W'(kinds[p]));
			write_reg(REG_LOOP_LENGTH, CFG_DATA_W'(loops[p]));
			if (p < 2) begin
				// overfill one table so the drop on a full table is hit
				send(mk(CMD_CLEAR, CH_POS, 0, 0, 0, 0, 0));
				for (int k = 0; k < MAX_KEYS + 2; k++) begin
					send(mk(CMD_ADD, p[1:0], $urandom_range(0, spans[p]), $urandom, $urandom,
						$urandom, 0));
				end
			end
			for (int k = 0; k < 75; k++) send(rand_req(spans[p]));
			drain();
		end
		if (errors == 0)
			$display("tb_keyframe_vector_interpolator_core: clean");
		else
			$display("tb_keyframe_vector_interpolator_core: errors");
		$finish;
	end

endmodule

[files.f]
design/kvi_pkg.sv
design/kvi_cell.sv
design/kvi_div.sv
design/kvi_isqrt.sv
design/keyframe_vector_interpolator_core.sv
dv/tb_keyframe_vector_interpolator_core.sv
